### sv/wsdf_pkg.sv
package wsdf_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [6:0] LenCodeExt16 = 7'd126;
  localparam logic [6:0] LenCodeExt64 = 7'd127;
  localparam logic [2:0] ExtLenBytes  = 3'd2;
  localparam logic [2:0] MaskKeyBytes = 3'd4;

  localparam logic [2:0] PhFirst   = 3'd0;
  localparam logic [2:0] PhLen     = 3'd1;
  localparam logic [2:0] PhExt     = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhDone    = 3'd5;

  localparam logic [7:0] HdrClose  = 8'h88;
  localparam logic [7:0] HdrPing   = 8'h89;
  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindClose = 2'd1;
  localparam logic [1:0] KindPing  = 2'd2;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StTrunc = 2'd1,
    StUnsup = 2'd2
  } status_e;

  // One request from the parser to the output side.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       has_byte;
    logic       frame_end;
    status_e    status;
    logic [7:0] hdr;
  } req_t;

endpackage

### sv/websocket_frame_deframer_top.sv
// Receive-side WebSocket frame deframer with payload unmasking.
// The input channel (in_valid_i, in_stall_o) takes the bytes of one received
// buffer, one per request, with buffer_end_i set on the final byte.
// The output channel (out_valid_o, out_stall_i) gives zero or one result per
// input byte: an unmasked payload byte, a frame-end marker with its status
// (ok, truncated or unsupported 64-bit length) and the frame kind.
// One byte is accepted every cycle while in_stall_o is low. The parser handles a
// byte in the cycle it is offered and writes its result into the queue at the
// accepting edge; the output register loads from the queue when it is empty or
// its result is being taken, so a result passes through the queue and then the
// output register before it is presented.
// A short queue sits between the parser and the output register, so the
// parser keeps taking bytes while the receiver stalls; in_stall_o rises
// only once that queue is full.
// Reset clears the parser to expect a new frame and empties the queue and
// the output register.
module websocket_frame_deframer_top import wsdf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       has_byte_o,
  output logic       frame_end_o,
  output logic [1:0] status_o,
  output logic [1:0] frame_kind_o
);

  logic full, push, pop, q_valid;
  req_t push_req, pop_req;

  assign in_stall_o = full;

  wsdf_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .full_i       (full),
    .push_o       (push),
    .req_o        (push_req)
  );

  wsdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_req_o  (pop_req)
  );

  wsdf_exec u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_req_i        (pop_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .has_byte_o     (has_byte_o),
    .frame_end_o    (frame_end_o),
    .status_o       (status_o),
    .frame_kind_o   (frame_kind_o)
  );

endmodule

### sv/wsdf_parse.sv
module wsdf_parse import wsdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_end_i,
  input  logic       full_i,
  output logic       push_o,
  output req_t       req_o
);

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [7:0]  hdr_q, hdr_d;
  logic        mask_q, mask_d;
  logic [31:0] key_q, key_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;

  logic        accept;
  logic        ended, was_done, has, known, begin_pl;
  logic [15:0] known_len, bp_len;
  logic [7:0]  key_b;
  status_e     status;

  assign accept = in_valid_i && !full_i;

  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    hdr_d     = hdr_q;
    mask_d    = mask_q;
    key_d     = key_q;
    len_d     = len_q;
    pos_d     = pos_q;
    ended     = 1'b0;
    was_done  = 1'b0;
    has       = 1'b0;
    known     = 1'b0;
    begin_pl  = 1'b0;
    known_len = len_q;
    bp_len    = len_q;
    key_b     = 8'd0;
    status    = StOk;

    unique case (phase_q)
      PhFirst: begin
        hdr_d   = data_byte_i;
        mask_d  = 1'b0;
        key_d   = '0;
        len_d   = '0;
        pos_d   = '0;
        hcnt_d  = '0;
        phase_d = PhLen;
      end
      PhLen: begin
        mask_d = data_byte_i[7];
        if (data_byte_i[6:0] == LenCodeExt64) begin
          phase_d = PhDone;
          ended   = 1'b1;
          status  = StUnsup;
        end else if (data_byte_i[6:0] == LenCodeExt16) begin
          phase_d = PhExt;
          hcnt_d  = '0;
          len_d   = '0;
        end else begin
          len_d     = {9'd0, data_byte_i[6:0]};
          known     = 1'b1;
          known_len = len_d;
        end
      end
      PhExt: begin
        len_d  = {len_q[7:0], data_byte_i};
        hcnt_d = 3'(hcnt_q + 3'd1);
        if (hcnt_d >= ExtLenBytes) begin
          known     = 1'b1;
          known_len = len_d;
        end
      end
      PhMask: begin
        key_d  = {key_q[23:0], data_byte_i};
        hcnt_d = 3'(hcnt_q + 3'd1);
        if (hcnt_d >= MaskKeyBytes) begin
          begin_pl = 1'b1;
          bp_len   = len_q;
        end
      end
      PhPayload: begin
        if (mask_q) begin
          case (pos_q[1:0])
            2'd0:    key_b = key_q[31:24];
            2'd1:    key_b = key_q[23:16];
            2'd2:    key_b = key_q[15:8];
            default: key_b = key_q[7:0];
          endcase
        end
        has   = 1'b1;
        pos_d = 16'(pos_q + 16'd1);
        if (pos_d == len_q) begin
          phase_d = PhDone;
          ended   = 1'b1;
        end
      end
      default: begin
        was_done = 1'b1;
      end
    endcase

    if (known) begin
      if (mask_d) begin
        phase_d = PhMask;
        hcnt_d  = '0;
        key_d   = '0;
      end else begin
        begin_pl = 1'b1;
        bp_len   = known_len;
      end
    end

    if (begin_pl) begin
      pos_d = '0;
      if (bp_len == 16'd0) begin
        phase_d = PhDone;
        ended   = 1'b1;
      end else begin
        phase_d = PhPayload;
      end
    end

    if (buffer_end_i && !ended && !was_done) begin
      ended  = 1'b1;
      status = StTrunc;
      has    = 1'b0;
    end

    // The end of a buffer always starts the next frame afresh.
    if (buffer_end_i) begin
      phase_d = PhFirst;
      hcnt_d  = '0;
      hdr_d   = '0;
      mask_d  = 1'b0;
      key_d   = '0;
      len_d   = '0;
      pos_d   = '0;
    end
  end

  assign push_o          = accept && (has || ended);
  assign req_o.data      = data_byte_i;
  assign req_o.key       = key_b;
  assign req_o.has_byte  = has;
  assign req_o.frame_end = ended;
  assign req_o.status    = status;
  assign req_o.hdr       = (phase_q == PhFirst) ? data_byte_i : hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      hcnt_q  <= '0;
      hdr_q   <= '0;
      mask_q  <= 1'b0;
      key_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hdr_q   <= hdr_d;
      mask_q  <= mask_d;
      key_q   <= key_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

### sv/wsdf_queue.sv
module wsdf_queue import wsdf_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t pop_req_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign pop_req_o = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

### sv/wsdf_exec.sv
module wsdf_exec import wsdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  req_t       q_req_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       has_byte_o,
  output logic       frame_end_o,
  output logic [1:0] status_o,
  output logic [1:0] frame_kind_o
);

  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       has_q;
  logic       end_q;
  logic [1:0] status_q, status_d;
  logic [1:0] kind_q, kind_d;

  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    byte_d   = q_req_i.has_byte ? (q_req_i.data ^ q_req_i.key) : 8'd0;
    status_d = q_req_i.frame_end ? q_req_i.status : StOk;
    kind_d   = KindOther;
    if (q_req_i.frame_end) begin
      if (q_req_i.hdr == HdrClose) begin
        kind_d = KindClose;
      end else if (q_req_i.hdr == HdrPing) begin
        kind_d = KindPing;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= byte_d;
      has_q    <= q_req_i.has_byte;
      end_q    <= q_req_i.frame_end;
      status_q <= status_d;
      kind_q   <= kind_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = byte_q;
  assign has_byte_o     = has_q;
  assign frame_end_o    = end_q;
  assign status_o       = status_q;
  assign frame_kind_o   = kind_q;

endmodule

### verif/websocket_frame_deframer_top_test.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_top_test;
  import wsdf_pkg::*;

  localparam int unsigned TargetItems   = 1900;
  localparam int unsigned TailItems     = 150;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       ends_buffer;
  } wire_byte_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       has_byte;
    logic       frame_end;
    status_e    status;
    logic [1:0] kind;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       buffer_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       has_byte_o;
  logic       frame_end_o;
  logic [1:0] status_o;
  logic [1:0] frame_kind_o;

  websocket_frame_deframer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .buffer_end_i  (buffer_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .payload_byte_o(payload_byte_o),
    .has_byte_o    (has_byte_o),
    .frame_end_o   (frame_end_o),
    .status_o      (status_o),
    .frame_kind_o  (frame_kind_o)
  );

  always #5 clk_i = ~clk_i;

  wire_byte_t   pending_bytes[$];
  logic [7:0]   frame_bytes[$];
  result_t      due_results[$];

  logic [2:0]   phase = PhFirst;
  logic [2:0]   hdr_count = '0;
  logic [7:0]   first_hdr = '0;
  logic         mask_on = 1'b0;
  logic [31:0]  mask_key = '0;
  logic [15:0]  pay_len = '0;
  logic [15:0]  pay_pos = '0;

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_ok = 0;
  int unsigned frames_trunc = 0;
  int unsigned frames_unsup = 0;
  int unsigned close_frames = 0;
  int unsigned ping_frames = 0;
  int unsigned bytes_unmasked = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic        quiet_tail = 1'b0;
  logic        receiver_holding = 1'b0;
  wire_byte_t  upcoming;
  result_t     want;

  task automatic clear_parser();
    phase = PhFirst;
    hdr_count = '0;
    first_hdr = '0;
    mask_on = 1'b0;
    mask_key = '0;
    pay_len = '0;
    pay_pos = '0;
  endtask

  task automatic append_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endtask

  function automatic logic start_payload();
    pay_pos = '0;
    if (pay_len == 16'd0) begin
      phase = PhDone;
      return 1'b1;
    end
    phase = PhPayload;
    return 1'b0;
  endfunction

  function automatic logic finish_length();
    if (mask_on) begin
      phase = PhMask;
      hdr_count = '0;
      mask_key = '0;
      return 1'b0;
    end
    return start_payload();
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic ends_buffer);
    result_t    r;
    logic       ended;
    logic       emit;
    logic       was_done;
    logic [7:0] k;
    r = '0;
    r.status = StOk;
    ended = 1'b0;
    emit = 1'b0;
    was_done = 1'b0;
    case (phase)
      PhFirst: begin
        first_hdr = b;
        mask_on = 1'b0;
        mask_key = '0;
        pay_len = '0;
        pay_pos = '0;
        hdr_count = '0;
        phase = PhLen;
      end
      PhLen: begin
        mask_on = b[7];
        if (b[6:0] == LenCodeExt64) begin
          phase = PhDone;
          ended = 1'b1;
          r.status = StUnsup;
        end else if (b[6:0] == LenCodeExt16) begin
          phase = PhExt;
          hdr_count = '0;
          pay_len = '0;
        end else begin
          pay_len = {9'd0, b[6:0]};
          ended = finish_length();
        end
      end
      PhExt: begin
        pay_len = {pay_len[7:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= ExtLenBytes) ended = finish_length();
      end
      PhMask: begin
        mask_key = {mask_key[23:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= MaskKeyBytes) ended = start_payload();
      end
      PhPayload: begin
        k = mask_on ? mask_key[8 * (3 - pay_pos[1:0]) +: 8] : 8'h00;
        r.payload = b ^ k;
        r.has_byte = 1'b1;
        emit = 1'b1;
        pay_pos = pay_pos + 16'd1;
        if (pay_pos == pay_len) begin
          phase = PhDone;
          ended = 1'b1;
        end
      end
      default: was_done = 1'b1;
    endcase
    if (ends_buffer && !ended && !was_done) begin
      ended = 1'b1;
      r.status = StTrunc;
      r.payload = '0;
      r.has_byte = 1'b0;
    end
    if (ended) begin
      emit = 1'b1;
      r.frame_end = 1'b1;
      r.kind = (first_hdr == HdrClose) ? KindClose :
               (first_hdr == HdrPing) ? KindPing : KindOther;
      case (r.status)
        StOk:    frames_ok++;
        StTrunc: frames_trunc++;
        default: frames_unsup++;
      endcase
      if (r.kind == KindClose) close_frames++;
      if (r.kind == KindPing) ping_frames++;
    end
    if (r.has_byte) bytes_unmasked++;
    if (emit) due_results = {due_results, r};
    if (ends_buffer) clear_parser();
  endtask

  task automatic commit_buffer();
    wire_byte_t w;
    foreach (frame_bytes[i]) begin
      w.data = frame_bytes[i];
      w.ends_buffer = (i == frame_bytes.size() - 1);
      pending_bytes = {pending_bytes, w};
    end
    frame_bytes.delete();
  endtask

  // Mostly well-formed frames with random content, some with a 64-bit length code, some cut short, a few pure noise.
  task automatic build_random_buffer(output int unsigned useful);
    int unsigned pick;
    int unsigned len_r;
    int unsigned n_pay;
    int unsigned cut;
    logic        masked;
    logic [7:0]  first;
    frame_bytes.delete();
    pick = $urandom_range(0, 99);
    masked = 1'($urandom_range(0, 1));
    len_r = 0;
    case ($urandom_range(0, 9))
      0:       first = HdrClose;
      1:       first = HdrPing;
      default: first = 8'($urandom);
    endcase
    if (pick < 5) begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
      useful = frame_bytes.size();
    end else begin
      append_byte(first);
      if (pick < 13) begin
        append_byte({masked, LenCodeExt64});
      end else begin
        if (pick < 33) begin
          len_r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 200);
          append_byte({masked, LenCodeExt16});
          append_byte(len_r[15:8]);
          append_byte(len_r[7:0]);
        end else begin
          len_r = (pick < 45) ? $urandom_range(0, 125) : $urandom_range(0, 12);
          append_byte({masked, 7'(len_r)});
        end
        if (masked) repeat (4) append_byte(8'($urandom));
        n_pay = (len_r > 300) ? $urandom_range(0, 20) : len_r;
        repeat (n_pay) append_byte(8'($urandom));
      end
      useful = frame_bytes.size();
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        if (useful > cut) useful = cut;
      end
    end
    commit_buffer();
  endtask

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'h00;
      buffer_end_i <= 1'b0;
      quiet_tail <= 1'b0;
      gap_left = 0;
      clear_parser();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(data_byte_i, buffer_end_i);
        bytes_sent++;
      end
      quiet_tail <= (pending_bytes.size() < TailItems);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!quiet_tail && !receiver_holding && (bytes_sent / 250) % 3 != 2 &&
                     $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          upcoming = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= upcoming.data;
          buffer_end_i <= upcoming.ends_buffer;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      receiver_holding <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected result: payload_byte %0h has_byte %0b frame_end %0b",
                 payload_byte_o, has_byte_o, frame_end_o);
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", want.payload, payload_byte_o);
          check_field("has_byte", 8'(want.has_byte), 8'(has_byte_o));
          check_field("frame_end", 8'(want.frame_end), 8'(frame_end_o));
          check_field("status", 8'(want.status), 8'(status_o));
          check_field("frame_kind", 8'(want.kind), 8'(frame_kind_o));
        end
        // Hold the output long enough for the internal queue to fill.
        if (results_seen == 150 || results_seen == 900) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && (results_seen / 200) % 3 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      receiver_holding <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stim_items;
    int unsigned n;
    stim_items = 0;
    frame_bytes = '{8'h81, 8'h00, 8'h33};
    commit_buffer();
    frame_bytes = '{HdrClose, 8'h82, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hFF, 8'h00};
    commit_buffer();
    frame_bytes = '{8'h82, 8'h7F, 8'hFF};
    commit_buffer();
    frame_bytes = '{HdrPing};
    commit_buffer();
    frame_bytes = '{8'h02, 8'h7E, 8'h00, 8'h01, 8'h55};
    commit_buffer();
    frame_bytes = '{HdrPing, 8'h05, 8'hAA};
    commit_buffer();
    stim_items = pending_bytes.size();
    while (stim_items < TargetItems) begin
      build_random_buffer(n);
      stim_items += n;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes and checked %0d results (%0d payload bytes unmasked).",
             bytes_sent, results_seen, bytes_unmasked);
    $display("Frames: %0d complete, %0d cut short, %0d 64-bit; %0d close, %0d ping.",
             frames_ok, frames_trunc, frames_unsup, close_frames, ping_frames);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/wsdf_pkg.sv
sv/wsdf_parse.sv
sv/wsdf_queue.sv
sv/wsdf_exec.sv
sv/websocket_frame_deframer_top.sv
verif/websocket_frame_deframer_top_test.sv
